// ===== src/cpu_data_op_execute_8bit_defines.svh =====
// ----------------------------------------------------------------------------
// cpu_data_op_execute_8bit_defines.svh
// Assertion macros used by the checker file of the execute unit.
// ----------------------------------------------------------------------------
`ifndef CPU_DATA_OP_EXECUTE_8BIT_DEFINES_SVH
`define CPU_DATA_OP_EXECUTE_8BIT_DEFINES_SVH

// Same-cycle implication: consequent must hold at the edge the antecedent holds.
`define CDX_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: consequent must hold after the antecedent.
`define CDX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cdx_pkg.sv =====
// ----------------------------------------------------------------------------
// cdx_pkg
// Opcode encoding, status bit positions, reset values and shared types of
// the 8-bit execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cdx_pkg;

   typedef enum logic [5:0] {
      OP_ADC    = 6'd0,
      OP_SBC    = 6'd1,
      OP_AND    = 6'd2,
      OP_ORA    = 6'd3,
      OP_EOR    = 6'd4,
      OP_BIT    = 6'd5,
      OP_CMP    = 6'd6,
      OP_CPX    = 6'd7,
      OP_CPY    = 6'd8,
      OP_LDA    = 6'd9,
      OP_LDX    = 6'd10,
      OP_LDY    = 6'd11,
      OP_ASL_A  = 6'd12,
      OP_LSR_A  = 6'd13,
      OP_ROL_A  = 6'd14,
      OP_ROR_A  = 6'd15,
      OP_ASL_M  = 6'd16,
      OP_LSR_M  = 6'd17,
      OP_ROL_M  = 6'd18,
      OP_ROR_M  = 6'd19,
      OP_INC_M  = 6'd20,
      OP_DEC_M  = 6'd21,
      OP_INX    = 6'd22,
      OP_INY    = 6'd23,
      OP_DEX    = 6'd24,
      OP_DEY    = 6'd25,
      OP_TAX    = 6'd26,
      OP_TAY    = 6'd27,
      OP_TXA    = 6'd28,
      OP_TYA    = 6'd29,
      OP_TSX    = 6'd30,
      OP_TXS    = 6'd31,
      OP_CLC    = 6'd32,
      OP_SEC    = 6'd33,
      OP_CLI    = 6'd34,
      OP_SEI    = 6'd35,
      OP_CLD    = 6'd36,
      OP_SED    = 6'd37,
      OP_CLV    = 6'd38,
      OP_STA    = 6'd39,
      OP_STX    = 6'd40,
      OP_STY    = 6'd41,
      OP_PHA    = 6'd42,
      OP_PHP    = 6'd43,
      OP_PLA    = 6'd44,
      OP_PLP    = 6'd45,
      OP_BPL    = 6'd46,
      OP_BMI    = 6'd47,
      OP_BVC    = 6'd48,
      OP_BVS    = 6'd49,
      OP_BCC    = 6'd50,
      OP_BCS    = 6'd51,
      OP_BNE    = 6'd52,
      OP_BEQ    = 6'd53,
      OP_NOP    = 6'd54
   } mode_type;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_U = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0] ACC_RESET    = 8'h00;
   localparam logic [7:0] INDEX_RESET  = 8'h00;
   localparam logic [7:0] STATUS_RESET = 8'h04;
   localparam logic [7:0] STACK_RESET  = 8'hFF;

   // Architectural registers of the unit.
   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] idx_x;
      logic [7:0] idx_y;
      logic [7:0] status;
      logic [7:0] sp;
   } arch_type;

   // Everything one operation produces.
   typedef struct packed {
      arch_type   arch;
      logic [7:0] data;
      logic       we;
      logic       taken;
   } exec_type;

endpackage

`default_nettype wire

// ===== src/cdx_if.sv =====
// ----------------------------------------------------------------------------
// cdx_if
// Valid/ready channels of the execute unit: operation request and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdx_req_if;
   logic       valid;
   logic       ready;
   logic [5:0] mode;
   logic [7:0] operand;

   modport source (output valid, output mode, output operand, input ready);
   modport sink   (input valid, input mode, input operand, output ready);
endinterface

interface cdx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic       write_enable;
   logic [7:0] acc_out;
   logic [7:0] x_out;
   logic [7:0] y_out;
   logic [7:0] flags_out;
   logic [7:0] stack_out;
   logic       branch_taken;

   modport source (output valid, output data_out, output write_enable, output acc_out,
                   output x_out, output y_out, output flags_out, output stack_out,
                   output branch_taken, input ready);
   modport sink   (input valid, input data_out, input write_enable, input acc_out,
                   input x_out, input y_out, input flags_out, input stack_out,
                   input branch_taken, output ready);
endinterface

`default_nettype wire

// ===== src/cpu_data_op_execute_8bit.sv =====
// ----------------------------------------------------------------------------
// cpu_data_op_execute_8bit
// Data-path execute unit of an 8-bit 6502-style processor: holds A, X, Y,
// status and stack pointer and performs one data operation per beat.
//
//   channel   dir   beat carries
//   req_bus   in    mode, operand
//   rsp_bus   out   data_out, write_enable, acc/x/y/flags/stack_out, branch_taken
//
// A request beat is held in the input register, then the ALU pass updates the
// registers and loads the result register.
// Throughput is one beat per cycle unless a result stalls; the ALU is combinational.
// Reset (synchronous, active high) sets A, X, Y to 0, status to 0x04 and the
// stack pointer to 0xFF, and empties both registers of the pipe.
// A stalled result holds; the input register still takes a beat while it is
// empty, and req_bus.ready drops only when both stages are full and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_data_op_execute_8bit (
   input  wire logic  clock,
   input  wire logic  reset,
   cdx_req_if.sink    req_bus,
   cdx_rsp_if.source  rsp_bus
);
   import cdx_pkg::*;

   logic       in_vld_ff;
   logic       in_vld_in;
   logic [5:0] in_mode_ff;
   logic [7:0] in_operand_ff;
   logic       req_take;
   logic       exec_go;

   arch_type   arch_ff;
   arch_type   arch_in;
   exec_type   exec;

   logic       out_vld_ff;
   logic       out_vld_in;
   exec_type   out_ff;

   cdx_alu u_alu (
      .arch    (arch_ff),
      .mode    (in_mode_ff),
      .operand (in_operand_ff),
      .result  (exec)
   );

   // advance the input register into the result register when it has room
   assign exec_go       = in_vld_ff & (~out_vld_ff | rsp_bus.ready);
   assign req_bus.ready = ~in_vld_ff | exec_go;
   assign req_take      = req_bus.valid & req_bus.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (exec_go) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (exec_go) begin
         out_vld_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_in = 1'b0;
      end
      arch_in = exec_go ? exec.arch : arch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff      <= 1'b0;
         out_vld_ff     <= 1'b0;
         arch_ff.acc    <= ACC_RESET;
         arch_ff.idx_x  <= INDEX_RESET;
         arch_ff.idx_y  <= INDEX_RESET;
         arch_ff.status <= STATUS_RESET;
         arch_ff.sp     <= STACK_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         arch_ff    <= arch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff    <= req_bus.mode;
         in_operand_ff <= req_bus.operand;
      end
      if (exec_go) begin
         out_ff <= exec;
      end
   end

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.data_out     = out_ff.data;
   assign rsp_bus.write_enable = out_ff.we;
   assign rsp_bus.acc_out      = out_ff.arch.acc;
   assign rsp_bus.x_out        = out_ff.arch.idx_x;
   assign rsp_bus.y_out        = out_ff.arch.idx_y;
   assign rsp_bus.flags_out    = out_ff.arch.status;
   assign rsp_bus.stack_out    = out_ff.arch.sp;
   assign rsp_bus.branch_taken = out_ff.taken;

endmodule

`default_nettype wire

// ===== src/cdx_alu.sv =====
// ----------------------------------------------------------------------------
// cdx_alu
// Single-pass data operation: from the current registers, an opcode and an
// operand byte, forms the next registers, the write-back byte and the
// branch condition.
// ----------------------------------------------------------------------------
`default_nettype none

module cdx_alu (
   input  wire cdx_pkg::arch_type arch,
   input  wire logic [5:0]        mode,
   input  wire logic [7:0]        operand,
   output      cdx_pkg::exec_type result
);
   import cdx_pkg::*;

   mode_type   op;
   logic [7:0] add_a;
   logic [7:0] add_b;
   logic       add_cin;
   logic [8:0] sum;
   logic       add_ovf;
   logic [7:0] sh_src;
   logic [7:0] sh_res;
   logic       sh_cout;
   logic [7:0] nz_val;
   logic       nz_upd;

   assign op = mode_type'(mode);

   // Shared adder: ADC, SBC (inverted operand) and compares (inverted, carry in set).
   always_comb begin
      add_a   = arch.acc;
      add_b   = ~operand;
      add_cin = 1'b1;
      unique case (op) inside
         OP_ADC: begin
            add_b   = operand;
            add_cin = arch.status[FLAG_C];
         end
         OP_SBC: add_cin = arch.status[FLAG_C];
         OP_CPX: add_a = arch.idx_x;
         OP_CPY: add_a = arch.idx_y;
         default: ;
      endcase
   end

   assign sum     = {1'b0, add_a} + {1'b0, add_b} + {8'd0, add_cin};
   assign add_ovf = ~(add_a[7] ^ add_b[7]) & (add_a[7] ^ sum[7]);

   // Shifter: bit 2 of the opcode picks accumulator over memory operand,
   // the low two bits pick ASL, LSR, ROL, ROR.
   always_comb begin
      sh_src = mode[2] ? arch.acc : operand;
      case (mode[1:0])
         2'd0: begin
            sh_cout = sh_src[7];
            sh_res  = {sh_src[6:0], 1'b0};
         end
         2'd1: begin
            sh_cout = sh_src[0];
            sh_res  = {1'b0, sh_src[7:1]};
         end
         2'd2: begin
            sh_cout = sh_src[7];
            sh_res  = {sh_src[6:0], arch.status[FLAG_C]};
         end
         default: begin
            sh_cout = sh_src[0];
            sh_res  = {arch.status[FLAG_C], sh_src[7:1]};
         end
      endcase
   end

   always_comb begin
      result       = '0;
      result.arch  = arch;
      nz_val       = 8'd0;
      nz_upd       = 1'b0;
      unique case (op) inside
         OP_ADC, OP_SBC: begin
            result.arch.acc            = sum[7:0];
            result.arch.status[FLAG_C] = sum[8];
            result.arch.status[FLAG_V] = add_ovf;
            nz_val = sum[7:0];
            nz_upd = 1'b1;
         end
         OP_AND: begin
            result.arch.acc = arch.acc & operand;
            nz_val = arch.acc & operand;
            nz_upd = 1'b1;
         end
         OP_ORA: begin
            result.arch.acc = arch.acc | operand;
            nz_val = arch.acc | operand;
            nz_upd = 1'b1;
         end
         OP_EOR: begin
            result.arch.acc = arch.acc ^ operand;
            nz_val = arch.acc ^ operand;
            nz_upd = 1'b1;
         end
         OP_BIT: begin
            result.arch.status[FLAG_Z] = (arch.acc & operand) == 8'd0;
            result.arch.status[FLAG_N] = operand[7];
            result.arch.status[FLAG_V] = operand[6];
         end
         OP_CMP, OP_CPX, OP_CPY: begin
            result.arch.status[FLAG_C] = sum[8];
            nz_val = sum[7:0];
            nz_upd = 1'b1;
         end
         OP_LDA: begin
            result.arch.acc = operand;
            nz_val = operand;
            nz_upd = 1'b1;
         end
         OP_LDX: begin
            result.arch.idx_x = operand;
            nz_val = operand;
            nz_upd = 1'b1;
         end
         OP_LDY: begin
            result.arch.idx_y = operand;
            nz_val = operand;
            nz_upd = 1'b1;
         end
         OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: begin
            result.arch.acc            = sh_res;
            result.arch.status[FLAG_C] = sh_cout;
            nz_val = sh_res;
            nz_upd = 1'b1;
         end
         OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin
            result.data                = sh_res;
            result.we                  = 1'b1;
            result.arch.status[FLAG_C] = sh_cout;
            nz_val = sh_res;
            nz_upd = 1'b1;
         end
         OP_INC_M: begin
            result.data = operand + 8'd1;
            result.we   = 1'b1;
            nz_val = operand + 8'd1;
            nz_upd = 1'b1;
         end
         OP_DEC_M: begin
            result.data = operand - 8'd1;
            result.we   = 1'b1;
            nz_val = operand - 8'd1;
            nz_upd = 1'b1;
         end
         OP_INX: begin
            result.arch.idx_x = arch.idx_x + 8'd1;
            nz_val = arch.idx_x + 8'd1;
            nz_upd = 1'b1;
         end
         OP_INY: begin
            result.arch.idx_y = arch.idx_y + 8'd1;
            nz_val = arch.idx_y + 8'd1;
            nz_upd = 1'b1;
         end
         OP_DEX: begin
            result.arch.idx_x = arch.idx_x - 8'd1;
            nz_val = arch.idx_x - 8'd1;
            nz_upd = 1'b1;
         end
         OP_DEY: begin
            result.arch.idx_y = arch.idx_y - 8'd1;
            nz_val = arch.idx_y - 8'd1;
            nz_upd = 1'b1;
         end
         OP_TAX: begin
            result.arch.idx_x = arch.acc;
            nz_val = arch.acc;
            nz_upd = 1'b1;
         end
         OP_TAY: begin
            result.arch.idx_y = arch.acc;
            nz_val = arch.acc;
            nz_upd = 1'b1;
         end
         OP_TXA: begin
            result.arch.acc = arch.idx_x;
            nz_val = arch.idx_x;
            nz_upd = 1'b1;
         end
         OP_TYA: begin
            result.arch.acc = arch.idx_y;
            nz_val = arch.idx_y;
            nz_upd = 1'b1;
         end
         OP_TSX: begin
            result.arch.idx_x = arch.sp;
            nz_val = arch.sp;
            nz_upd = 1'b1;
         end
         OP_TXS: result.arch.sp = arch.idx_x;
         OP_CLC: result.arch.status[FLAG_C] = 1'b0;
         OP_SEC: result.arch.status[FLAG_C] = 1'b1;
         OP_CLI: result.arch.status[FLAG_I] = 1'b0;
         OP_SEI: result.arch.status[FLAG_I] = 1'b1;
         OP_CLD: result.arch.status[FLAG_D] = 1'b0;
         OP_SED: result.arch.status[FLAG_D] = 1'b1;
         OP_CLV: result.arch.status[FLAG_V] = 1'b0;
         OP_STA: begin
            result.data = arch.acc;
            result.we   = 1'b1;
         end
         OP_STX: begin
            result.data = arch.idx_x;
            result.we   = 1'b1;
         end
         OP_STY: begin
            result.data = arch.idx_y;
            result.we   = 1'b1;
         end
         OP_PHA: begin
            result.data    = arch.acc;
            result.we      = 1'b1;
            result.arch.sp = arch.sp - 8'd1;
         end
         OP_PHP: begin
            // push the status image with B and the unused bit forced high
            result.data         = arch.status;
            result.data[FLAG_B] = 1'b1;
            result.data[FLAG_U] = 1'b1;
            result.we           = 1'b1;
            result.arch.sp      = arch.sp - 8'd1;
         end
         OP_PLA: begin
            result.arch.acc = operand;
            result.arch.sp  = arch.sp + 8'd1;
            nz_val = operand;
            nz_upd = 1'b1;
         end
         OP_PLP: begin
            // drop B and the unused bit, they are not held in the register
            result.arch.status         = operand;
            result.arch.status[FLAG_B] = 1'b0;
            result.arch.status[FLAG_U] = 1'b0;
            result.arch.sp             = arch.sp + 8'd1;
         end
         OP_BPL: result.taken = ~arch.status[FLAG_N];
         OP_BMI: result.taken =  arch.status[FLAG_N];
         OP_BVC: result.taken = ~arch.status[FLAG_V];
         OP_BVS: result.taken =  arch.status[FLAG_V];
         OP_BCC: result.taken = ~arch.status[FLAG_C];
         OP_BCS: result.taken =  arch.status[FLAG_C];
         OP_BNE: result.taken = ~arch.status[FLAG_Z];
         OP_BEQ: result.taken =  arch.status[FLAG_Z];
         default: ;
      endcase
      if (nz_upd) begin
         result.arch.status[FLAG_Z] = nz_val == 8'd0;
         result.arch.status[FLAG_N] = nz_val[7];
      end
   end

endmodule

`default_nettype wire

// ===== src/cdx_checker.sv =====
// ----------------------------------------------------------------------------
// cdx_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cpu_data_op_execute_8bit_defines.svh"

module cdx_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_data_out,
   input wire logic       rsp_write_enable,
   input wire logic [7:0] rsp_flags_out
);

   // reset empties the result register
   `CDX_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // a beat without write_enable carries no stray byte
   `CDX_ASSERT_SAME(a_idle_data_zero, clock, reset, rsp_valid && !rsp_write_enable,
                    rsp_data_out == 8'd0, "data_out nonzero without write_enable")

   // B and the unused bit never live in the status register
   `CDX_ASSERT_SAME(a_status_bits_clear, clock, reset, rsp_valid,
                    rsp_flags_out[5:4] == 2'b00, "status bits 5:4 set")

   // an empty result side always leaves room for a request
   `CDX_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid, req_ready,
                    "request stalled with empty result register")

   // a stalled result holds
   `CDX_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_data_out) && $stable(rsp_flags_out),
                    "stalled result changed")

endmodule

bind cpu_data_op_execute_8bit cdx_checker u_cdx_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_data_out     (rsp_bus.data_out),
   .rsp_write_enable (rsp_bus.write_enable),
   .rsp_flags_out    (rsp_bus.flags_out)
);

`default_nettype wire
